// ===== hdl/cils_pkg.sv =====
`timescale 1ns / 1ps
// shared types, character codes and helpers for the c integer literal scanner
// no dependencies; imported by the scanner top level and its checker
package cils_pkg;

  // result and internal field widths
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned ERR_W     = 3;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ESC_W     = 9;
  localparam int unsigned ESC_DIG_W = 2;
  localparam int unsigned OUT_DATA_W = 48;

  // scan phases
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_SIGN   = 4'd1,
    PH_ZERO   = 4'd2,
    PH_HEXPFX = 4'd3,
    PH_DIGITS = 4'd4,
    PH_SUFU   = 4'd5,
    PH_SUFL   = 4'd6,
    PH_QOPEN  = 4'd7,
    PH_QESC   = 4'd8,
    PH_QHEX1  = 4'd9,
    PH_QHEX2  = 4'd10,
    PH_QOCT   = 4'd11,
    PH_QCLOSE = 4'd12
  } phase_e;

  // number base
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_CLOSE  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_HEX   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_ESC   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_ESC_RANGE = 3'd4;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_D0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_D1     = 8'h31;
  localparam logic [CHAR_W-1:0] CH_D7     = 8'h37;
  localparam logic [CHAR_W-1:0] CH_D9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3f;
  localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_F   = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UC_L   = 8'h4c;
  localparam logic [CHAR_W-1:0] CH_UC_U   = 8'h55;
  localparam logic [CHAR_W-1:0] CH_UC_X   = 8'h58;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_B   = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LC_F   = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LC_L   = 8'h6c;
  localparam logic [CHAR_W-1:0] CH_LC_N   = 8'h6e;
  localparam logic [CHAR_W-1:0] CH_LC_R   = 8'h72;
  localparam logic [CHAR_W-1:0] CH_LC_T   = 8'h74;
  localparam logic [CHAR_W-1:0] CH_LC_U   = 8'h75;
  localparam logic [CHAR_W-1:0] CH_LC_V   = 8'h76;
  localparam logic [CHAR_W-1:0] CH_LC_X   = 8'h78;

  // control codes produced by the simple escapes
  localparam logic [CHAR_W-1:0] CC_BEL = 8'd7;
  localparam logic [CHAR_W-1:0] CC_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CC_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CC_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CC_VT  = 8'd11;
  localparam logic [CHAR_W-1:0] CC_FF  = 8'd12;
  localparam logic [CHAR_W-1:0] CC_CR  = 8'd13;

  // hex digit value of a character, 16 when it is no hex digit
  localparam logic [4:0] NOT_HEX = 5'd16;

  function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
    logic [4:0] d;
    d = NOT_HEX;
    if (c >= CH_D0 && c <= CH_D9) begin
      d = 5'(c - CH_D0);
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      d = 5'(c - CH_LC_A + 8'd10);
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      d = 5'(c - CH_UC_A + 8'd10);
    end
    return d;
  endfunction

  // numeric base as a digit bound
  function automatic logic [4:0] radix_num(input radix_e r);
    logic [4:0] n;
    case (r)
      RADIX_HEX: n = 5'd16;
      RADIX_OCT: n = 5'd8;
      default:   n = 5'd10;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/c_integer_literal_scanner_top.sv =====
`timescale 1ns / 1ps
// c integer literal and character constant scanner, one character per word
// depends on cils_pkg
//
// Characters arrive one per word on the slave stream, with tuser[0] set on the
// character that begins a new scan. The block recognises a signed decimal, octal
// or hex integer literal with optional U/L suffixes, or a quoted character
// constant with escapes, and emits one result word when the token ends (found,
// value, error code, characters consumed). It takes one character every cycle
// when the result side keeps up; a result word is presented from the result
// register: the character that ends the token sits in the input register
// while the per-character state update works on it, and the update loads
// the result register. The sustained rate of one character per cycle is set
// by that state update loop, a shift-add and a classification of the
// character. The accumulator is VALUE_BITS wide; the reported value is it
// sign-extended or truncated to 32 bits.
module c_integer_literal_scanner_top #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic [0:0]  s_axis_tuser,   // [0] start_req
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [0] found, [32:1] value, [35:33] error_code,
                                      // [43:36] consumed, [47:44] zero
);
  import cils_pkg::*;

  // input register
  logic                in_valid_q, in_valid_d;
  logic [CHAR_W-1:0]   ch_q;
  logic                start_q;

  // scan state
  phase_e                  phase_q, phase_d;
  logic [VALUE_BITS-1:0]   acc_q, acc_d;
  logic                    neg_q, neg_d;
  radix_e                  radix_q, radix_d;
  logic [ESC_W-1:0]        esc_val_q, esc_val_d;
  logic [ESC_DIG_W-1:0]    esc_dig_q, esc_dig_d;
  logic [ERR_W-1:0]        perr_q, perr_d;
  logic [COUNT_W-1:0]      cnt_q, cnt_d;

  // result register
  logic                    out_valid_q, out_valid_d;
  logic                    found_q;
  logic [VALUE_W-1:0]      value_q;
  logic [ERR_W-1:0]        err_q;
  logic [COUNT_W-1:0]      consumed_q;

  // combinational result of one step
  logic                    emit;
  logic                    e_found;
  logic [VALUE_W-1:0]      e_value;
  logic [ERR_W-1:0]        e_err;

  logic                    proc;
  logic                    in_take;

  // handshake
  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, consumed_q, err_q, value_q, found_q};

  // per-character state update
  always_comb begin
    logic [COUNT_W-1:0]    cnt_base;
    logic [ERR_W-1:0]      perr_base;
    logic [4:0]            d;
    logic                  number_out;
    logic                  fail_out;
    logic                  close_chk;
    logic                  first_chk;
    logic                  suffix_chk;
    logic                  octal_fin;
    logic [CHAR_W-1:0]     esc_char;
    logic                  esc_set;
    logic signed [VALUE_BITS-1:0] num_s;

    phase_d    = phase_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    radix_d    = radix_q;
    esc_val_d  = esc_val_q;
    esc_dig_d  = esc_dig_q;
    perr_d     = perr_q;
    cnt_d      = cnt_q;
    emit       = 1'b0;
    e_found    = 1'b0;
    e_value    = '0;
    e_err      = ERR_NONE;
    number_out = 1'b0;
    fail_out   = 1'b0;
    close_chk  = 1'b0;
    first_chk  = 1'b0;
    suffix_chk = 1'b0;
    octal_fin  = 1'b0;
    esc_char   = CH_SPACE;
    esc_set    = 1'b0;
    d          = hex_digit(ch_q);
    num_s      = '0;

    cnt_base  = start_q ? '0 : cnt_q;
    perr_base = start_q ? ERR_NONE : perr_q;

    if (start_q) begin
      // new scan clears everything
      acc_d     = '0;
      neg_d     = 1'b0;
      radix_d   = RADIX_DEC;
      esc_val_d = '0;
      esc_dig_d = '0;
      perr_d    = ERR_NONE;
      cnt_d     = '0;
      if (ch_q == CH_QUOTE) begin
        cnt_d   = COUNT_W'(1);
        phase_d = PH_QOPEN;
      end else if (ch_q == CH_PLUS || ch_q == CH_MINUS) begin
        neg_d   = (ch_q == CH_MINUS);
        cnt_d   = COUNT_W'(1);
        phase_d = PH_SIGN;
      end else begin
        first_chk = 1'b1;
      end
    end else begin
      case (phase_q)
        PH_SIGN: begin
          first_chk = 1'b1;
        end
        PH_ZERO: begin
          if (ch_q == CH_LC_X || ch_q == CH_UC_X) begin
            cnt_d   = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
            phase_d = PH_HEXPFX;
          end else begin
            phase_d    = PH_DIGITS;
            suffix_chk = 1'b1;
          end
        end
        PH_HEXPFX: begin
          if (d < NOT_HEX) begin
            acc_d   = VALUE_BITS'(d);
            radix_d = RADIX_HEX;
            cnt_d   = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
            phase_d = PH_DIGITS;
          end else begin
            emit    = 1'b1;
            e_err   = ERR_BAD_HEX;
          end
        end
        PH_DIGITS: begin
          suffix_chk = 1'b1;
        end
        PH_SUFU: begin
          if (ch_q == CH_LC_L || ch_q == CH_UC_L) begin
            cnt_d = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
          end
          number_out = 1'b1;
        end
        PH_SUFL: begin
          if (ch_q == CH_LC_U || ch_q == CH_UC_U) begin
            cnt_d = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
          end
          number_out = 1'b1;
        end
        PH_QOPEN: begin
          if (ch_q == CH_NUL) begin
            fail_out = 1'b1;
          end else begin
            cnt_d = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
            if (ch_q == CH_BSLASH) begin
              phase_d = PH_QESC;
            end else begin
              acc_d   = VALUE_BITS'(ch_q);
              phase_d = PH_QCLOSE;
            end
          end
        end
        PH_QESC: begin
          case (ch_q)
            CH_QMARK:  begin esc_char = CH_QMARK;  esc_set = 1'b1; end
            CH_LC_A:   begin esc_char = CC_BEL;    esc_set = 1'b1; end
            CH_LC_B:   begin esc_char = CC_BS;     esc_set = 1'b1; end
            CH_LC_F:   begin esc_char = CC_FF;     esc_set = 1'b1; end
            CH_LC_N:   begin esc_char = CC_LF;     esc_set = 1'b1; end
            CH_LC_R:   begin esc_char = CC_CR;     esc_set = 1'b1; end
            CH_LC_T:   begin esc_char = CC_TAB;    esc_set = 1'b1; end
            CH_LC_V:   begin esc_char = CC_VT;     esc_set = 1'b1; end
            CH_DQUOTE: begin esc_char = CH_DQUOTE; esc_set = 1'b1; end
            CH_QUOTE:  begin esc_char = CH_QUOTE;  esc_set = 1'b1; end
            CH_BSLASH: begin esc_char = CH_BSLASH; esc_set = 1'b1; end
            CH_LC_X, CH_UC_X: begin
              esc_val_d = '0;
              cnt_d     = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
              phase_d   = PH_QHEX1;
            end
            CH_NUL: begin
              perr_d   = (perr_base == ERR_NONE) ? ERR_BAD_ESC : perr_base;
              fail_out = 1'b1;
            end
            default: begin
              if (ch_q inside {[CH_D0:CH_D7]}) begin
                esc_val_d = ESC_W'(ch_q - CH_D0);
                esc_dig_d = ESC_DIG_W'(1);
                cnt_d     = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
                phase_d   = PH_QOCT;
              end else begin
                // illegal escape reads as a space
                perr_d   = (perr_base == ERR_NONE) ? ERR_BAD_ESC : perr_base;
                esc_char = CH_SPACE;
                esc_set  = 1'b1;
              end
            end
          endcase
          if (esc_set) begin
            acc_d   = VALUE_BITS'(esc_char);
            cnt_d   = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
            phase_d = PH_QCLOSE;
          end
        end
        PH_QHEX1, PH_QHEX2: begin
          if (ch_q == CH_NUL) begin
            perr_d   = (perr_base == ERR_NONE) ? ERR_BAD_HEX : perr_base;
            fail_out = 1'b1;
          end else begin
            // bad hex digit counts as zero
            if (d == NOT_HEX) begin
              perr_d = (perr_base == ERR_NONE) ? ERR_BAD_HEX : perr_base;
              d      = '0;
            end
            cnt_d = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
            if (phase_q == PH_QHEX1) begin
              esc_val_d = ESC_W'(d);
              phase_d   = PH_QHEX2;
            end else begin
              acc_d   = VALUE_BITS'({esc_val_q[3:0], d[3:0]});
              phase_d = PH_QCLOSE;
            end
          end
        end
        PH_QOCT: begin
          if (ch_q inside {[CH_D0:CH_D7]}) begin
            esc_val_d = {esc_val_q[ESC_W-4:0], 3'(ch_q - CH_D0)};
            esc_dig_d = esc_dig_q + 1'b1;
            cnt_d     = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
            if (esc_dig_d == ESC_DIG_W'(3)) begin
              octal_fin = 1'b1;
            end
          end else begin
            octal_fin = 1'b1;
            close_chk = 1'b1;
          end
        end
        PH_QCLOSE: begin
          close_chk = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    // end of an octal escape, values above a byte read as a space
    if (octal_fin) begin
      if (esc_val_d > ESC_W'(255)) begin
        perr_d = (perr_d == ERR_NONE) ? ERR_ESC_RANGE : perr_d;
        acc_d  = VALUE_BITS'(CH_SPACE);
      end else begin
        acc_d  = VALUE_BITS'(esc_val_d);
      end
      phase_d = PH_QCLOSE;
    end

    // first digit of a number
    if (first_chk) begin
      if (ch_q == CH_D0) begin
        radix_d = RADIX_OCT;
        cnt_d   = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
        phase_d = PH_ZERO;
      end else if (ch_q inside {[CH_D1:CH_D9]}) begin
        acc_d   = VALUE_BITS'(ch_q - CH_D0);
        radix_d = RADIX_DEC;
        cnt_d   = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
        phase_d = PH_DIGITS;
      end else begin
        cnt_d = '0;
        emit  = 1'b1;
      end
    end

    // further digit, else a suffix letter, else the number ends
    if (suffix_chk) begin
      if (d < radix_num(radix_q)) begin
        case (radix_q)
          RADIX_HEX: acc_d = {acc_q[VALUE_BITS-5:0], 4'b0000} + VALUE_BITS'(d);
          RADIX_OCT: acc_d = {acc_q[VALUE_BITS-4:0], 3'b000} + VALUE_BITS'(d);
          default:   acc_d = {acc_q[VALUE_BITS-4:0], 3'b000}
                           + {acc_q[VALUE_BITS-2:0], 1'b0} + VALUE_BITS'(d);
        endcase
        cnt_d = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
      end else if (ch_q == CH_LC_U || ch_q == CH_UC_U) begin
        cnt_d   = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
        phase_d = PH_SUFU;
      end else if (ch_q == CH_LC_L || ch_q == CH_UC_L) begin
        cnt_d   = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
        phase_d = PH_SUFL;
      end else begin
        number_out = 1'b1;
      end
    end

    // closing quote check
    if (close_chk) begin
      if (ch_q == CH_QUOTE) begin
        cnt_d   = (cnt_d == '1) ? cnt_d : cnt_d + 1'b1;
        emit    = 1'b1;
        e_found = 1'b1;
        e_value = VALUE_W'($signed(acc_d[7:0]));
        e_err   = perr_d;
      end else begin
        fail_out = 1'b1;
      end
    end

    // number result, negated after a minus sign, and sign-extended
    if (number_out) begin
      num_s   = neg_q ? $signed(-acc_q) : $signed(acc_q);
      emit    = 1'b1;
      e_found = 1'b1;
      e_value = VALUE_W'(num_s);
      e_err   = ERR_NONE;
    end

    // failed character constant
    if (fail_out) begin
      emit    = 1'b1;
      e_found = 1'b0;
      e_value = '0;
      e_err   = (perr_d != ERR_NONE) ? perr_d : ERR_NO_CLOSE;
    end

    if (emit) begin
      phase_d = PH_IDLE;
    end
  end

  // handshake next values
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      radix_q     <= RADIX_DEC;
      esc_val_q   <= '0;
      esc_dig_q   <= '0;
      perr_q      <= ERR_NONE;
      cnt_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (proc) begin
        phase_q   <= phase_d;
        acc_q     <= acc_d;
        neg_q     <= neg_d;
        radix_q   <= radix_d;
        esc_val_q <= esc_val_d;
        esc_dig_q <= esc_dig_d;
        perr_q    <= perr_d;
        cnt_q     <= cnt_d;
      end
    end
  end

  // input and result payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q    <= s_axis_tdata;
      start_q <= s_axis_tuser[0];
    end
    if (proc && emit) begin
      found_q    <= e_found;
      value_q    <= e_value;
      err_q      <= e_err;
      consumed_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/cils_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the c integer literal scanner
// depends on cils_pkg; bound to c_integer_literal_scanner_top
module cils_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  import cils_pkg::*;

  logic              found;
  logic [VALUE_W-1:0] value;
  logic [ERR_W-1:0]  err;

  assign found = m_axis_tdata[0];
  assign value = m_axis_tdata[32:1];
  assign err   = m_axis_tdata[35:33];

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:44] == 4'b0000)
    else $error("result pad bits set");

  // nothing recognised means a zero value
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !found |-> value == '0)
    else $error("value set without a token");

  // error code range, and a missing quote never comes with a token
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (err <= ERR_ESC_RANGE) && !(found && err == ERR_NO_CLOSE))
    else $error("bad error code in result word");

  // input side is ready while the result register is empty and nothing is pending
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !$past(s_axis_tvalid) |-> s_axis_tready)
    else $error("input stalled with empty pipeline");

endmodule

bind c_integer_literal_scanner_top cils_checker u_cils_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
